### rtl/gcenc_pkg.sv
// Shared types, constants and the command template of the goto command encoder.
package gcenc_pkg;

  localparam int unsigned CMD_LEN = 35;
  localparam int unsigned SLOT_W  = 6;

  typedef logic [SLOT_W-1:0] slot_t;

  // Byte positions of the variable fields within the command.
  localparam slot_t SLOT_RA    = 6'd8;
  localparam slot_t SLOT_SIGN  = 6'd21;
  localparam slot_t SLOT_DEC   = 6'd22;
  localparam slot_t SLOT_LAST  = 6'd34;

  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CHR_PLUS  = 8'h2b;
  localparam logic [7:0] CHR_MINUS = 8'h2d;
  localparam logic [7:0] DEG_SIGN  = 8'd223;

  // Declination in arc seconds, offset by half a turn, and its fold points.
  localparam logic [20:0] DEC_TURN    = 21'd1296000;
  localparam logic [20:0] DEC_HALF    = 21'd648000;
  localparam logic [20:0] DEC_QUARTER = 21'd324000;
  localparam logic [20:0] DEC_3QUART  = 21'd972000;

  localparam logic [16:0] RA_TURN = 17'd86400;

  localparam logic [7:0] CMD_TEMPLATE [CMD_LEN] = '{
    8'h23, 8'h3a, 8'h51, 8'h23, 8'h3a, 8'h53, 8'h72, 8'h20,
    8'h30, 8'h30, 8'h3a, 8'h30, 8'h30, 8'h3a, 8'h30, 8'h30,
    8'h23, 8'h3a, 8'h53, 8'h64, 8'h20,
    8'h2b,
    8'h30, 8'h30, 8'hdf, 8'h30, 8'h30, 8'h3a, 8'h30, 8'h30,
    8'h23, 8'h3a, 8'h4d, 8'h53, 8'h23
  };

  // Rounded angles: RA in time seconds, Dec as sign and arc-second magnitude.
  typedef struct packed {
    logic [16:0] ra_sec;
    logic [18:0] dec_mag;
    logic        dec_neg;
  } coord_sec_t;

  typedef struct packed {
    logic [3:0] big_hi;
    logic [3:0] big_lo;
    logic [3:0] min_hi;
    logic [3:0] min_lo;
    logic [3:0] sec_hi;
    logic [3:0] sec_lo;
  } sexa_t;

  typedef struct packed {
    sexa_t ra;
    sexa_t dec;
    logic  dec_neg;
  } coord_digits_t;

endpackage

### rtl/gcenc_digits.sv
// Pipelined split of both angles into two-digit sexagesimal fields.
module gcenc_digits (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  gcenc_pkg::coord_sec_t    in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output gcenc_pkg::coord_digits_t out_data_o
);
  import gcenc_pkg::*;

  function automatic logic [7:0] split2(input logic [6:0] x);
    logic [13:0] p;
    logic [3:0]  t;
    logic [6:0]  o;
    p = 14'(x) * 14'd103;
    t = p[13:10];
    o = x - 7'(t) * 7'd10;
    return {t, o[3:0]};
  endfunction

  logic [4:0] vld_q;
  logic [5:0] rdy;

  logic [18:0] v_in [2];

  logic [18:0] v1_q   [2];
  logic [6:0]  big1_q [2];
  logic [11:0] rem2_q [2];
  logic [7:0]  bigd2_q [2];
  logic [11:0] rem3_q [2];
  logic [5:0]  min3_q [2];
  logic [7:0]  bigd3_q [2];
  logic [5:0]  sec4_q [2];
  logic [7:0]  bigd4_q [2];
  logic [7:0]  mind4_q [2];
  logic [7:0]  bigd5_q [2];
  logic [7:0]  mind5_q [2];
  logic [7:0]  secd5_q [2];
  logic [4:0]  neg_q;

  logic [38:0] p1   [2];
  logic [18:0] rem2 [2];
  logic [24:0] p3   [2];
  logic [11:0] sec4 [2];

  assign v_in[0] = {2'b00, in_data_i.ra_sec};
  assign v_in[1] = in_data_i.dec_mag;

  always_comb begin
    rdy[5] = out_ready_i;
    for (int k = 4; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end
  assign in_ready_o = rdy[0];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      p1[l]   = 39'(v_in[l]) * 39'd596524;
      rem2[l] = v1_q[l] - 19'(big1_q[l]) * 19'd3600;
      p3[l]   = 25'(rem2_q[l]) * 25'd4370;
      sec4[l] = rem3_q[l] - 12'(min3_q[l]) * 12'd60;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) vld_q[0] <= in_valid_i;
      for (int k = 1; k < 5; k++) begin
        if (rdy[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && in_valid_i) begin
      neg_q[0] <= in_data_i.dec_neg;
      for (int l = 0; l < 2; l++) begin
        v1_q[l]   <= v_in[l];
        big1_q[l] <= p1[l][37:31];
      end
    end
    if (rdy[1] && vld_q[0]) begin
      neg_q[1] <= neg_q[0];
      for (int l = 0; l < 2; l++) begin
        rem2_q[l]  <= rem2[l][11:0];
        bigd2_q[l] <= split2(big1_q[l]);
      end
    end
    if (rdy[2] && vld_q[1]) begin
      neg_q[2] <= neg_q[1];
      for (int l = 0; l < 2; l++) begin
        rem3_q[l]  <= rem2_q[l];
        min3_q[l]  <= p3[l][23:18];
        bigd3_q[l] <= bigd2_q[l];
      end
    end
    if (rdy[3] && vld_q[2]) begin
      neg_q[3] <= neg_q[2];
      for (int l = 0; l < 2; l++) begin
        sec4_q[l]  <= sec4[l][5:0];
        bigd4_q[l] <= bigd3_q[l];
        mind4_q[l] <= split2({1'b0, min3_q[l]});
      end
    end
    if (rdy[4] && vld_q[3]) begin
      neg_q[4] <= neg_q[3];
      for (int l = 0; l < 2; l++) begin
        bigd5_q[l] <= bigd4_q[l];
        mind5_q[l] <= mind4_q[l];
        secd5_q[l] <= split2({1'b0, sec4_q[l]});
      end
    end
  end

  assign out_valid_o = vld_q[4];
  assign out_data_o  = '{
    ra:  '{big_hi: bigd5_q[0][7:4], big_lo: bigd5_q[0][3:0],
           min_hi: mind5_q[0][7:4], min_lo: mind5_q[0][3:0],
           sec_hi: secd5_q[0][7:4], sec_lo: secd5_q[0][3:0]},
    dec: '{big_hi: bigd5_q[1][7:4], big_lo: bigd5_q[1][3:0],
           min_hi: mind5_q[1][7:4], min_lo: mind5_q[1][3:0],
           sec_hi: secd5_q[1][7:4], sec_lo: secd5_q[1][3:0]},
    dec_neg: neg_q[4]
  };

endmodule

### rtl/goto_command_encoder_core.sv
// Top level of the goto command encoder: angle rounding, folding and byte output.
//
// Each input transfer carries an RA and a declination angle as binary fractions of a
// turn and produces one 35-byte ASCII command "#:Q#:Sr HH:MM:SS#:Sd sDD(223)MM:SS#:MS#",
// one byte per output transfer, with tlast on the final byte. The output side moves one
// byte per cycle while m_axis_tready is high, and the next command is loaded as the last
// byte of the previous one is taken. Inputs pass through a nine-stage pipeline (rounding
// multiplies, pole fold, digit split) ahead of the output stage, and the pipeline keeps
// taking inputs while a command is still being sent, until its stages are full.
module goto_command_encoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // ra_angle [31:0], dec_angle [63:32]
  input  logic [63:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_byte [7:0]
  output logic [7:0]  m_axis_tdata,
  output logic        m_axis_tlast
);
  import gcenc_pkg::*;

  logic [3:0] vld_q;
  logic [3:0] rdy;

  logic [31:0] ra1_q, ra2_q, ra3_q;
  logic [31:0] dec1_q;
  logic [20:0] dec2_q;
  logic [18:0] mag3_q;
  logic        neg3_q;
  coord_sec_t  coord4_q;

  logic [52:0] dec_prod;
  logic [48:0] ra_prod;
  logic [20:0] mag_full;
  logic        neg_d;
  logic        fold_d;
  logic [16:0] ra_sec_d;

  logic          dig_valid;
  logic          dig_ready;
  coord_digits_t dig_data;

  logic          ser_vld_q;
  slot_t         slot_q;
  coord_digits_t ser_q;
  logic          out_done;

  assign rdy[3] = !vld_q[3] || dig_ready;
  assign rdy[2] = !vld_q[2] || rdy[3];
  assign rdy[1] = !vld_q[1] || rdy[2];
  assign rdy[0] = !vld_q[0] || rdy[1];
  assign s_axis_tready = rdy[0];

  always_comb begin
    dec_prod = 53'({~dec1_q[31], dec1_q[30:0]}) * 53'd1296000 + 53'h80000000;

    fold_d = 1'b0;
    if (dec2_q < DEC_QUARTER) begin
      mag_full = dec2_q;
      neg_d    = (dec2_q != '0);
      fold_d   = 1'b1;
    end else if (dec2_q > DEC_3QUART) begin
      mag_full = DEC_TURN - dec2_q;
      neg_d    = 1'b0;
      fold_d   = 1'b1;
    end else if (dec2_q < DEC_HALF) begin
      mag_full = DEC_HALF - dec2_q;
      neg_d    = 1'b1;
    end else begin
      mag_full = dec2_q - DEC_HALF;
      neg_d    = 1'b0;
    end

    ra_prod  = 49'(ra3_q) * 49'd86400 + 49'h80000000;
    ra_sec_d = (ra_prod[48:32] >= RA_TURN) ? '0 : ra_prod[48:32];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) vld_q[0] <= s_axis_tvalid;
      if (rdy[1]) vld_q[1] <= vld_q[0];
      if (rdy[2]) vld_q[2] <= vld_q[1];
      if (rdy[3]) vld_q[3] <= vld_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && s_axis_tvalid) begin
      ra1_q  <= s_axis_tdata[31:0];
      dec1_q <= s_axis_tdata[63:32];
    end
    if (rdy[1] && vld_q[0]) begin
      ra2_q  <= ra1_q;
      dec2_q <= dec_prod[52:32];
    end
    if (rdy[2] && vld_q[1]) begin
      ra3_q  <= {ra2_q[31] ^ fold_d, ra2_q[30:0]};
      mag3_q <= mag_full[18:0];
      neg3_q <= neg_d;
    end
    if (rdy[3] && vld_q[2]) begin
      coord4_q <= '{ra_sec: ra_sec_d, dec_mag: mag3_q, dec_neg: neg3_q};
    end
  end

  gcenc_digits u_digits (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (vld_q[3]),
    .in_ready_o  (dig_ready),
    .in_data_i   (coord4_q),
    .out_valid_o (dig_valid),
    .out_ready_i (out_done || !ser_vld_q),
    .out_data_o  (dig_data)
  );

  assign out_done = ser_vld_q && m_axis_tready && (slot_q == SLOT_LAST);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_vld_q <= 1'b0;
      slot_q    <= '0;
    end else if (dig_valid && (out_done || !ser_vld_q)) begin
      ser_vld_q <= 1'b1;
      slot_q    <= '0;
    end else if (ser_vld_q && m_axis_tready) begin
      if (slot_q == SLOT_LAST) begin
        ser_vld_q <= 1'b0;
      end else begin
        slot_q <= slot_q + 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (dig_valid && (out_done || !ser_vld_q)) begin
      ser_q <= dig_data;
    end
  end

  always_comb begin
    case (slot_q)
      SLOT_RA:            m_axis_tdata = CHR_ZERO + 8'(ser_q.ra.big_hi);
      SLOT_RA + 6'd1:     m_axis_tdata = CHR_ZERO + 8'(ser_q.ra.big_lo);
      SLOT_RA + 6'd3:     m_axis_tdata = CHR_ZERO + 8'(ser_q.ra.min_hi);
      SLOT_RA + 6'd4:     m_axis_tdata = CHR_ZERO + 8'(ser_q.ra.min_lo);
      SLOT_RA + 6'd6:     m_axis_tdata = CHR_ZERO + 8'(ser_q.ra.sec_hi);
      SLOT_RA + 6'd7:     m_axis_tdata = CHR_ZERO + 8'(ser_q.ra.sec_lo);
      SLOT_SIGN:          m_axis_tdata = ser_q.dec_neg ? CHR_MINUS : CHR_PLUS;
      SLOT_DEC:           m_axis_tdata = CHR_ZERO + 8'(ser_q.dec.big_hi);
      SLOT_DEC + 6'd1:    m_axis_tdata = CHR_ZERO + 8'(ser_q.dec.big_lo);
      SLOT_DEC + 6'd2:    m_axis_tdata = DEG_SIGN;
      SLOT_DEC + 6'd3:    m_axis_tdata = CHR_ZERO + 8'(ser_q.dec.min_hi);
      SLOT_DEC + 6'd4:    m_axis_tdata = CHR_ZERO + 8'(ser_q.dec.min_lo);
      SLOT_DEC + 6'd6:    m_axis_tdata = CHR_ZERO + 8'(ser_q.dec.sec_hi);
      SLOT_DEC + 6'd7:    m_axis_tdata = CHR_ZERO + 8'(ser_q.dec.sec_lo);
      default: begin
        m_axis_tdata = (slot_q <= SLOT_LAST) ? CMD_TEMPLATE[slot_q] : '0;
      end
    endcase
  end

  assign m_axis_tvalid = ser_vld_q;
  assign m_axis_tlast  = (slot_q == SLOT_LAST);

endmodule

### sim/goto_command_encoder_core_tb.sv
// Testbench for goto_command_encoder_core: predicts each 35-byte goto command and checks it.
`timescale 1ns / 100ps

module goto_command_encoder_core_tb;
  import gcenc_pkg::CMD_LEN;
  import gcenc_pkg::DEG_SIGN;
  import gcenc_pkg::CHR_PLUS;
  import gcenc_pkg::CHR_MINUS;
  import gcenc_pkg::CHR_ZERO;

  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 300;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // ra_angle [31:0], dec_angle [63:32]
  logic [63:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // out_byte [7:0]
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;

  // Each entry holds {last, byte} of one expected output transfer.
  logic [8:0]  expected_bytes [$];
  logic [7:0]  cmd_text [$];

  int  mismatches    = 0;
  int  bytes_checked = 0;
  int  coords_sent   = 0;
  int  pole_folds    = 0;
  int  cycle_count   = 0;
  int  rx_hold_cycles = 0;
  bit  tx_gaps   = 1'b0;
  bit  rx_stalls = 1'b0;

  goto_command_encoder_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  function automatic void put_text(input string s);
    for (int i = 0; i < s.len(); i++) cmd_text.push_back(s[i]);
  endfunction

  function automatic void put_sexa(input int unsigned v, input logic [7:0] sep);
    int unsigned secs;
    int unsigned mins;
    int unsigned big;
    secs = v % 60;
    mins = (v / 60) % 60;
    big  = v / 3600;
    cmd_text.push_back(CHR_ZERO + 8'((big / 10) % 10));
    cmd_text.push_back(CHR_ZERO + 8'(big % 10));
    cmd_text.push_back(sep);
    cmd_text.push_back(CHR_ZERO + 8'(mins / 10));
    cmd_text.push_back(CHR_ZERO + 8'(mins % 10));
    cmd_text.push_back(":");
    cmd_text.push_back(CHR_ZERO + 8'(secs / 10));
    cmd_text.push_back(CHR_ZERO + 8'(secs % 10));
  endfunction

  // Rounds both angles, folds the declination over a pole and queues the command bytes.
  function automatic void predict_command(input logic [31:0] ra_in, input logic [31:0] dec_in);
    logic [31:0]     ra;
    longint unsigned dec_prod;
    longint unsigned ra_prod;
    longint          dec_sec;
    int unsigned     ra_sec;
    int unsigned     dec_mag;
    logic            dec_neg;
    ra = ra_in;
    dec_prod = {32'd0, ~dec_in[31], dec_in[30:0]};
    dec_prod = dec_prod * 64'd1296000 + 64'h8000_0000;
    dec_sec = longint'(dec_prod >> 32) - 648000;
    if (dec_sec < -324000) begin
      dec_sec = -648000 - dec_sec;
      ra = ra + 32'h8000_0000;
      pole_folds++;
    end else if (dec_sec > 324000) begin
      dec_sec = 648000 - dec_sec;
      ra = ra + 32'h8000_0000;
      pole_folds++;
    end
    ra_prod = {32'd0, ra};
    ra_prod = ra_prod * 64'd86400 + 64'h8000_0000;
    ra_sec = int'(ra_prod >> 32);
    if (ra_sec >= 86400) ra_sec = ra_sec - 86400;
    dec_neg = dec_sec < 0;
    dec_mag = 32'(dec_neg ? -dec_sec : dec_sec);
    cmd_text.delete();
    put_text("#:Q#:Sr ");
    put_sexa(ra_sec, ":");
    put_text("#:Sd ");
    cmd_text.push_back(dec_neg ? CHR_MINUS : CHR_PLUS);
    put_sexa(dec_mag, DEG_SIGN);
    put_text("#:MS#");
    foreach (cmd_text[i]) expected_bytes.push_back({i == CMD_LEN - 1, cmd_text[i]});
  endfunction

  task automatic note_mismatch(input string field, input logic [7:0] want,
                               input logic [7:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("Mismatch in %s at byte %0d: expected %02h, got %02h",
               field, bytes_checked, want, got);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected transfer: byte %02h, tlast %0b", m_axis_tdata, m_axis_tlast);
      end else begin
        if (m_axis_tdata !== expected_bytes[0][7:0])
          note_mismatch("out_byte", expected_bytes[0][7:0], m_axis_tdata);
        if (m_axis_tlast !== expected_bytes[0][8])
          note_mismatch("tlast", {7'd0, expected_bytes[0][8]}, {7'd0, m_axis_tlast});
        void'(expected_bytes.pop_front());
      end
      bytes_checked++;
    end
  end

  initial begin : rx_side
    int stall;
    stall = 0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
        rx_hold_cycles--;
      end else if (stall > 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else if (rx_stalls && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        stall = $urandom_range(1, 10) - 1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Timeout after %0d cycles", cycle_count);
    $display("*** FAILED ***");
    $finish;
  end

  // Entered and left at a falling edge.
  task automatic send_coord(input logic [31:0] ra, input logic [31:0] dec);
    int gap;
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= {$urandom, $urandom};
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {dec, ra};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_command(ra, dec);
    coords_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  function automatic logic [31:0] pick_ra();
    case ($urandom_range(0, 3))
      0: return 32'hFFFF_FFFF - $urandom_range(0, 100000);
      1: return $urandom_range(0, 100000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_dec();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return 32'h4000_0000 + $urandom_range(0, 8000) - 4000;
      2: return 32'hC000_0000 + $urandom_range(0, 8000) - 4000;
      3: return $urandom_range(0, 8000) - 4000;
      default: return {($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000, 16'($urandom)};
    endcase
  endfunction

  task automatic test_directed();
    tx_gaps   = 1'b0;
    rx_stalls = 1'b0;
    send_coord(32'h0000_0000, 32'h0000_0000);
    send_coord(32'hFFFF_FFFF, 32'h7FFF_FFFF);
    send_coord(32'h0000_0000, 32'h8000_0000);
    send_coord(32'h1234_5678, 32'h4000_0000);
    send_coord(32'h1234_5678, 32'h4000_0001);
    send_coord(32'h8765_4321, 32'hC000_0000);
    send_coord(32'h8765_4321, 32'hBFFF_FFFF);
    send_coord(32'hFFFF_FFFF, 32'h0000_0000);
    send_coord(32'h0100_0000, 32'h8100_0000);
    send_coord(32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_coord(32'hFFFF_0000, 32'hFFFF_0000);
    send_coord(32'h9000_0000, 32'h6000_0000);
    send_coord(32'hAAAA_AAAA, 32'h5555_5555);
    send_coord(32'h5555_5555, 32'hAAAA_AAAA);
    send_coord(32'hF000_0000, 32'h3FFF_F000);
    send_coord(32'h8000_0000, 32'hC000_1000);
    wait_drain();
  endtask

  // The receiver holds off while the sender keeps offering, so the input side stalls.
  task automatic test_backpressure();
    tx_gaps   = 1'b0;
    rx_stalls = 1'b0;
    rx_hold_cycles = HOLD_CYCLES;
    repeat (12) send_coord($urandom, pick_dec());
    wait_drain();
  endtask

  task automatic test_drain_pause();
    tx_gaps   = 1'b1;
    rx_stalls = 1'b1;
    repeat (4) send_coord(pick_ra(), pick_dec());
    wait_drain();
    repeat (4) send_coord(pick_ra(), pick_dec());
    wait_drain();
  endtask

  task automatic test_random(input int count, input bit with_idle);
    tx_gaps   = with_idle;
    rx_stalls = with_idle;
    repeat (count) send_coord(pick_ra(), pick_dec());
    wait_drain();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);
    test_directed();
    test_backpressure();
    test_drain_pause();
    test_random(230, 1'b1);
    test_random(45, 1'b0);
    $display("Sent %0d coordinate pairs and checked %0d command bytes, %0d with a pole fold.",
             coords_sent, bytes_checked, pole_folds);
    $display("Included a long output hold-off, drained pauses and runs without idling.");
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches in total", mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
